### hw/rtl/frc_pkg.sv
// Shared types and constants for the CRC-checked frame receiver.
package frc_pkg;

    localparam logic [7:0]  START_BYTE   = 8'hFB;
    localparam logic [8:0]  LEN_OVERHEAD = 9'd5;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h8408;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  FIXED_RESET   = 8'd0;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT   = 1'b0;
    localparam logic CFG_FIXED_LEN = 1'b1;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_CRC_OK  = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_res;
        logic [8:0] index;
        logic       last;
        t_status    status;
    } t_result;

endpackage

### hw/rtl/frc_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
interface frc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface frc_out_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [7:0] data_res;
    logic [8:0] index;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output has_data, output data_res, output index,
                    output last, output status, input ready);
    modport sink   (input valid, input has_data, input data_res, input index,
                    input last, input status, output ready);
endinterface

### hw/rtl/crc_checked_frame_receiver.sv
// Top level: config registers, input register, frame control and result register.
//
// Receiver for length-prefixed frames checked with CRC-16/MCRF4XX.
// Input channel i_in: one transaction per received byte (kind 0) or per time
// tick (kind 1). Output channel o_out: at most one result per input transaction:
// each frame byte with its index, the final byte flagged last with crc ok or
// crc error status, or a timeout marker (has_data 0, last 1, status 2).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 timeout_ticks, 1 fixed_length); write only while the block is idle.
// An accepted transaction waits in the input register, is processed from there
// into the result register, and its result is offered from that register.
// Throughput: one transaction per cycle while the output is not stalled; the
// bytewise CRC update and the frame decisions sit in one combinational step
// between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; ready drops only when both are occupied.
// Reset (synchronous, active low) empties both registers, restores the
// configuration defaults (timeout 1000 ticks, length from the frame) and
// returns the frame logic to hunting for the start byte.
module crc_checked_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frc_in_if.sink      i_in,
    frc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import frc_pkg::*;

    logic [15:0] r_timeout_ticks;
    logic [7:0]  r_fixed_length;
    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free, step, in_accept, res_valid;
    t_result     res;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_accept  = i_in.valid && i_in.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_fixed_length  <= FIXED_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TIMEOUT) begin
                r_timeout_ticks <= i_cfg_data;
            end else begin
                r_fixed_length <= i_cfg_data[7:0];
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind <= i_in.kind;
            r_in_data <= i_in.data;
        end
    end

    frc_frame_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_kind          (r_in_kind),
        .i_data          (r_in_data),
        .i_timeout_ticks (r_timeout_ticks),
        .i_fixed_length  (r_fixed_length),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.has_data = r_out.has_data;
    assign o_out.data_res = r_out.data_res;
    assign o_out.index    = r_out.index;
    assign o_out.last     = r_out.last;
    assign o_out.status   = r_out.status;

endmodule

### hw/rtl/frc_crc16.sv
// Bytewise CRC-16/MCRF4XX update (reflected poly 0x8408).
module frc_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import frc_pkg::*;

    // eight reflected shift steps on one byte
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

### hw/rtl/frc_frame_ctrl.sv
// Frame state, tick timeout and result generation for one item per step.
module frc_frame_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_kind,
    input  logic [7:0]      i_data,
    input  logic [15:0]     i_timeout_ticks,
    input  logic [7:0]      i_fixed_length,
    output logic            o_res_valid,
    output frc_pkg::t_result o_res
);
    import frc_pkg::*;

    logic        r_in_frame,     n_in_frame;
    logic [8:0]  r_byte_count,   n_byte_count;
    logic [8:0]  r_frame_length, n_frame_length;
    logic [15:0] r_crc,          n_crc;
    logic [15:0] r_tick_count,   n_tick_count;

    logic [15:0] crc_base, crc_fed, crc_eff;
    logic [8:0]  idx, flen_base, flen_eff;
    logic [16:0] tick_next;
    logic        timeout, start, active, done;

    frc_crc16 u_crc (
        .i_crc  (crc_base),
        .i_byte (i_data),
        .o_crc  (crc_fed)
    );

    // per-byte frame view: a start byte opens a frame in the same step
    assign start     = !r_in_frame && (i_data == START_BYTE);
    assign active    = r_in_frame || start;
    assign idx       = r_in_frame ? r_byte_count : 9'd0;
    assign crc_base  = r_in_frame ? r_crc : CRC_INIT;
    assign flen_base = r_in_frame ? r_frame_length : {1'b0, i_fixed_length};
    assign flen_eff  = (idx == 9'd1 && flen_base == 9'd0) ?
                       ({1'b0, i_data} + LEN_OVERHEAD) : flen_base;
    assign crc_eff   = (idx != 9'd0) ? crc_fed : crc_base;
    assign done      = (flen_eff != 9'd0) &&
                       (({1'b0, idx} + 10'd1) >= {1'b0, flen_eff});

    // tick window
    assign tick_next = {1'b0, r_tick_count} + 17'd1;
    assign timeout   = tick_next > {1'b0, i_timeout_ticks};

    // next state and result
    always_comb begin
        n_in_frame     = r_in_frame;
        n_byte_count   = r_byte_count;
        n_frame_length = r_frame_length;
        n_crc          = r_crc;
        n_tick_count   = r_tick_count;
        o_res_valid    = 1'b0;
        o_res          = '{has_data: 1'b0, data_res: 8'd0, index: 9'd0,
                           last: 1'b0, status: ST_CRC_OK};
        if (i_step) begin
            if (i_kind == KIND_TICK) begin
                if (timeout) begin
                    n_in_frame     = 1'b0;
                    n_byte_count   = 9'd0;
                    n_frame_length = 9'd0;
                    n_crc          = CRC_INIT;
                    n_tick_count   = 16'd0;
                    o_res_valid    = 1'b1;
                    o_res.last     = 1'b1;
                    o_res.status   = ST_TIMEOUT;
                end else begin
                    n_tick_count = tick_next[15:0];
                end
            end else if (active) begin
                o_res_valid       = 1'b1;
                o_res.has_data    = 1'b1;
                o_res.data_res    = i_data;
                o_res.index       = idx;
                if (done) begin
                    n_in_frame     = 1'b0;
                    n_byte_count   = 9'd0;
                    n_frame_length = 9'd0;
                    n_crc          = CRC_INIT;
                    n_tick_count   = 16'd0;
                    o_res.last     = 1'b1;
                    o_res.status   = (flen_eff >= 9'd3 && crc_eff == 16'd0) ?
                                     ST_CRC_OK : ST_CRC_ERR;
                end else begin
                    n_in_frame     = 1'b1;
                    n_byte_count   = idx + 9'd1;
                    n_frame_length = flen_eff;
                    n_crc          = crc_eff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame     <= 1'b0;
            r_byte_count   <= 9'd0;
            r_frame_length <= 9'd0;
            r_crc          <= CRC_INIT;
            r_tick_count   <= 16'd0;
        end else begin
            r_in_frame     <= n_in_frame;
            r_byte_count   <= n_byte_count;
            r_frame_length <= n_frame_length;
            r_crc          <= n_crc;
            r_tick_count   <= n_tick_count;
        end
    end

    // hunting state always holds a clean frame context
    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_byte_count == 9'd0 && r_crc == CRC_INIT))
        else $error("hunting with stale frame context");

    // an end-of-window result starts a fresh tick window
    a_window_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> (r_tick_count == 16'd0 && !r_in_frame))
        else $error("window not restarted after last result");

    // an open frame never runs past its known length
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_frame && r_frame_length != 9'd0) |-> (r_byte_count < r_frame_length))
        else $error("byte count beyond frame length");

    // a timeout result carries no frame byte
    a_timeout_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_TIMEOUT) |-> (!o_res.has_data && o_res.last))
        else $error("malformed timeout result");

endmodule

### dv/tb_crc_checked_frame_receiver.sv
// Self-checking testbench for the CRC-checked frame receiver.
`timescale 1ns / 100ps

module tb_crc_checked_frame_receiver;
    import frc_pkg::*;

    localparam int STALL_LIMIT = 1000;

    // Frame receiver behavior: predicts at most one result per accepted transaction and
    // checks the results that come out of the block in order.
    class rx_frame_predictor;
        t_result     expected_q[$];
        int          mismatches;
        logic [15:0] timeout_ticks;
        logic [7:0]  fixed_len;
        bit          in_frame;
        logic [8:0]  byte_cnt;
        logic [8:0]  frame_len;
        logic [15:0] crc;
        logic [15:0] tick_cnt;

        function new();
            mismatches    = 0;
            timeout_ticks = TIMEOUT_RESET;
            fixed_len     = FIXED_RESET;
            open_window();
        endfunction

        function void open_window();
            in_frame  = 1'b0;
            byte_cnt  = '0;
            frame_len = '0;
            crc       = CRC_INIT;
            tick_cnt  = '0;
        endfunction

        // Reflected CRC-16, one byte LSB first
        function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void write_reg(logic idx, logic [15:0] v);
            if (idx == CFG_TIMEOUT)
                timeout_ticks = v;
            else
                fixed_len = v[7:0];
        endfunction

        // Returns 1 when the transaction produces a result
        function bit accept_item(logic kind, logic [7:0] d);
            t_result     r;
            logic [16:0] next_ticks;
            logic [8:0]  idx;
            logic [9:0]  idx_next;
            r = '0;
            if (kind == KIND_TICK) begin
                next_ticks = {1'b0, tick_cnt} + 17'd1;
                if (next_ticks > {1'b0, timeout_ticks}) begin
                    open_window();
                    r.last   = 1'b1;
                    r.status = ST_TIMEOUT;
                    expected_q.push_back(r);
                    return 1'b1;
                end
                tick_cnt = next_ticks[15:0];
                return 1'b0;
            end
            // Hunting: only the start byte opens a frame
            if (!in_frame) begin
                if (d != START_BYTE)
                    return 1'b0;
                in_frame  = 1'b1;
                byte_cnt  = '0;
                crc       = CRC_INIT;
                frame_len = {1'b0, fixed_len};
            end
            idx = byte_cnt;
            if (idx >= 9'd1) begin
                crc = crc_byte(crc, d);
                if (idx == 9'd1 && frame_len == '0)
                    frame_len = {1'b0, d} + LEN_OVERHEAD;
            end
            byte_cnt   = idx + 9'd1;
            r.has_data = 1'b1;
            r.data_res = d;
            r.index    = idx;
            idx_next   = {1'b0, idx} + 10'd1;
            // Final byte: trailer included, good frame leaves the register at zero
            if (frame_len != '0 && idx_next >= {1'b0, frame_len}) begin
                r.last = 1'b1;
                if (frame_len >= 9'd3 && crc == 16'h0000)
                    r.status = ST_CRC_OK;
                else
                    r.status = ST_CRC_ERR;
                open_window();
            end
            expected_q.push_back(r);
            return 1'b1;
        endfunction

        function void cmp_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            cmp_field("has_data", exp_r.has_data, got.has_data);
            cmp_field("data_res", exp_r.data_res, got.data_res);
            cmp_field("index",    exp_r.index,    got.index);
            cmp_field("last",     exp_r.last,     got.last);
            cmp_field("status",   exp_r.status,   got.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;

    frc_in_if  in_ch();
    frc_out_if out_ch();

    crc_checked_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rx_frame_predictor model = new();
    logic [7:0]        frame_buf[$];
    int                results_due = 0;
    int                burst_left  = 0;
    int                stall_left  = 0;
    int                watchdog    = 0;
    logic [7:0]        rx_cycle    = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check every transaction, ready follows a rotating pattern
    always @(posedge i_clk) begin
        t_result got;
        if (out_ch.valid && out_ch.ready) begin
            got.has_data = out_ch.has_data;
            got.data_res = out_ch.data_res;
            got.index    = out_ch.index;
            got.last     = out_ch.last;
            got.status   = t_status'(out_ch.status);
            model.check_result(got);
        end
        rx_cycle++;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: out_ch.ready <= 1'b1;
                2'd1: out_ch.ready <= ($urandom_range(0, 9) < 7);
                2'd2: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 12);
                    end
                end
                default: out_ch.ready <= rx_cycle[0];
            endcase
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            watchdog = 0;
        end else begin
            watchdog++;
            if (watchdog >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // One input transaction; the sender runs in bursts with random gaps
    task automatic send_item(logic kind, logic [7:0] d);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.data  <= d;
        do @(posedge i_clk); while (!in_ch.ready);
        results_due += model.accept_item(kind, d);
    endtask

    // Stop sending, wait for all results, then cover the pipeline latency
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (model.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        model.write_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Frame image: fixed 0 builds a length-prefixed frame (start, length, command,
    // payload, trailer); otherwise a frame of exactly that many bytes
    task automatic build_frame(int fixed, int payload, bit corrupt);
        logic [15:0] c;
        int          pos;
        frame_buf.delete();
        frame_buf.push_back(START_BYTE);
        if (fixed == 0) begin
            frame_buf.push_back(payload[7:0]);
            repeat (payload + 1) frame_buf.push_back(8'($urandom));
        end else if (fixed >= 3) begin
            repeat (fixed - 3) frame_buf.push_back(8'($urandom));
        end else begin
            repeat (fixed - 1) frame_buf.push_back(8'($urandom));
        end
        if (fixed == 0 || fixed >= 3) begin
            c = CRC_INIT;
            for (int i = 1; i < frame_buf.size(); i++)
                c = model.crc_byte(c, frame_buf[i]);
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
        end
        if (corrupt && frame_buf.size() > 2) begin
            pos = $urandom_range(2, frame_buf.size() - 1);
            frame_buf[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
    endtask

    // Send part of the frame image, with ticks scattered in at tick_pct percent
    task automatic send_bytes(int first, int count, int tick_pct);
        for (int i = first; i < first + count; i++) begin
            if (tick_pct > 0 && $urandom_range(1, 100) <= tick_pct)
                send_item(KIND_TICK, 8'($urandom));
            send_item(KIND_BYTE, frame_buf[i]);
        end
    endtask

    // Mostly well-formed frames, plus line noise, tick runs and cut-off frames
    task automatic run_random(int fixed, int budget, int tick_pct);
        int start;
        int sel;
        int n;
        start = results_due;
        while (results_due - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                n = 0;
                if (fixed == 0)
                    n = ($urandom_range(0, 39) == 0) ? $urandom_range(11, 255)
                                                     : $urandom_range(0, 10);
                build_frame(fixed, n, $urandom_range(0, 4) == 0);
                send_bytes(0, frame_buf.size(), tick_pct);
            end else if (sel < 74) begin
                repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
            end else if (sel < 86) begin
                repeat ($urandom_range(1, 8)) send_item(KIND_TICK, 8'($urandom));
            end else if (sel < 97) begin
                build_frame(fixed, $urandom_range(0, 10), 1'b0);
                if (frame_buf.size() > 1)
                    send_bytes(0, $urandom_range(1, frame_buf.size() - 1), tick_pct);
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        logic [15:0] ph_timeout[6];
        int          ph_fixed[6];
        int          ph_budget[6];
        int          ph_tick[6];

        ph_timeout = '{16'd65535, 16'd30, 16'd1, 16'd700, 16'd2000, 16'd1000};
        ph_fixed   = '{0, 0, 0, 3, 255, 9};
        // the maximum fixed length phase runs about one frame
        ph_budget  = '{60, 40, 15, 20, 1, 25};
        ph_tick    = '{0, 4, 10, 2, 1, 3};

        in_ch.valid  <= 1'b0;
        in_ch.kind   <= KIND_BYTE;
        in_ch.data   <= 8'h00;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_TIMEOUT;
        cfg_data     <= 16'h0000;
        i_rst_n      <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise, shortest frame, bad crc
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_FIXED_LEN, 16'd0);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_TICK, 8'hFF);
        build_frame(0, 0, 1'b0);
        send_bytes(0, frame_buf.size(), 0);
        build_frame(0, 2, 1'b1);
        send_bytes(0, frame_buf.size(), 0);

        // Timeout while hunting and in the middle of a frame
        write_reg(CFG_TIMEOUT, 16'd1);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, START_BYTE);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'h2A);

        // Fixed lengths too short for a trailer
        write_reg(CFG_FIXED_LEN, 16'd1);
        send_item(KIND_BYTE, START_BYTE);
        write_reg(CFG_FIXED_LEN, 16'd2);
        send_item(KIND_BYTE, START_BYTE);
        send_item(KIND_BYTE, 8'h55);

        // Length rule latched at the start byte survives a later fixed length write
        write_reg(CFG_FIXED_LEN, 16'd0);
        build_frame(0, 0, 1'b0);
        send_bytes(0, 1, 0);
        write_reg(CFG_FIXED_LEN, 16'd3);
        send_bytes(1, frame_buf.size() - 1, 0);

        // Random phases over several register settings
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_TIMEOUT, ph_timeout[p]);
            write_reg(CFG_FIXED_LEN, 16'(ph_fixed[p]));
            run_random(ph_fixed[p], ph_budget[p], ph_tick[p]);
        end

        wait_drained();
        if (model.mismatches == 0 && model.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_stream_if.sv
hw/rtl/frc_crc16.sv
hw/rtl/frc_frame_ctrl.sv
hw/rtl/crc_checked_frame_receiver.sv
dv/tb_crc_checked_frame_receiver.sv
